@@ design/rpvs_pkg.sv @@
// Shared constants and types for the row profile variation score block.
`timescale 1ns / 1ps
`default_nettype none
package rpvs_pkg;

	// Stream word and lane split
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned NUM_LANES  = 4;
	localparam int unsigned LANE_W     = WORD_W / NUM_LANES;
	localparam int unsigned LANE_CNT_W = $clog2(LANE_W + 1);
	localparam int unsigned WORD_CNT_W = $clog2(WORD_W + 1);
	localparam int unsigned POS_W      = $clog2(WORD_W);

	// Configuration and result fields
	localparam int unsigned CFG_W       = 13;
	localparam int unsigned SCORE_OUT_W = 36;
	localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST = 13'd4096;

	// Default size limits
	localparam int unsigned DEF_MAX_WIDTH  = 4096;
	localparam int unsigned DEF_MAX_HEIGHT = 4096;

	// Word flags carried through the pipeline
	typedef struct packed {
		logic row_end;
		logic img_end;
	} word_flags_t;

	// Row-end flags handed to the square/accumulate stage
	typedef struct packed {
		logic add;
		logic img_end;
	} row_flags_t;

	// Mask that keeps the pixels of a row-ending word inside the image width
	function automatic logic [WORD_W-1:0] row_end_mask(input logic [CFG_W-1:0] width);
		logic [POS_W-1:0] last_pos;
		logic [POS_W-1:0] keep_shift;
		last_pos   = width[POS_W-1:0] - POS_W'(1);
		keep_shift = POS_W'(WORD_W - 1) - last_pos;
		return {WORD_W{1'b1}} << keep_shift;
	endfunction

endpackage
`default_nettype wire

@@ design/rpvs_lane.sv @@
// One popcount lane: counts black pixels in its slice of the word.
`timescale 1ns / 1ps
`default_nettype none
module rpvs_lane (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic [rpvs_pkg::LANE_W-1:0]     bits,
	output logic      [rpvs_pkg::LANE_CNT_W-1:0] cnt_s1
);
	import rpvs_pkg::*;

	logic [LANE_CNT_W-1:0] cnt;

	// Count ones in the slice
	always_comb begin
		cnt = '0;
		for (int i = 0; i < LANE_W; i++) begin
			cnt = cnt + LANE_CNT_W'(bits[i]);
		end
	end

	// Stage 1 register
	always_ff @(posedge clk) begin
		if (en) begin
			cnt_s1 <= cnt;
		end
	end

endmodule
`default_nettype wire

@@ design/rpvs_merge.sv @@
// Merge stage: sums lane counts, keeps the row counts, forms the row difference.
`timescale 1ns / 1ps
`default_nettype none
module rpvs_merge #(
	parameter int unsigned MAX_WIDTH = rpvs_pkg::DEF_MAX_WIDTH,
	localparam int unsigned CNT_W    = $clog2(MAX_WIDTH + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic [rpvs_pkg::NUM_LANES-1:0][rpvs_pkg::LANE_CNT_W-1:0] lane_cnt_s1,
	input  wire rpvs_pkg::word_flags_t   flags_s1,
	output logic      [CNT_W-1:0]        diff_s2,
	output rpvs_pkg::row_flags_t         flags_s2
);
	import rpvs_pkg::*;

	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      before_q;
	logic                  first_q;
	logic [WORD_CNT_W-1:0] word_cnt;
	logic [CNT_W:0]        cnt_sum;
	logic [CNT_W-1:0]      cnt_new;
	logic [CNT_W-1:0]      diff;

	// Lane merge and saturating row count
	always_comb begin
		word_cnt = '0;
		for (int i = 0; i < NUM_LANES; i++) begin
			word_cnt = word_cnt + WORD_CNT_W'(lane_cnt_s1[i]);
		end
		cnt_sum = (CNT_W + 1)'(cnt_q) + (CNT_W + 1)'(word_cnt);
		if (cnt_sum > (CNT_W + 1)'(MAX_WIDTH)) begin
			cnt_new = CNT_W'(MAX_WIDTH);
		end else begin
			cnt_new = cnt_sum[CNT_W-1:0];
		end
		diff = (cnt_new >= before_q) ? (cnt_new - before_q) : (before_q - cnt_new);
	end

	// Row state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			before_q <= '0;
			first_q  <= 1'b1;
		end else if (en) begin
			if (flags_s1.img_end) begin
				cnt_q    <= '0;
				before_q <= '0;
				first_q  <= 1'b1;
			end else if (flags_s1.row_end) begin
				cnt_q    <= '0;
				before_q <= cnt_new;
				first_q  <= 1'b0;
			end else begin
				cnt_q <= cnt_new;
			end
		end
	end

	// Stage 2 register
	always_ff @(posedge clk) begin
		if (en) begin
			diff_s2          <= diff;
			flags_s2.add     <= flags_s1.row_end && !first_q;
			flags_s2.img_end <= flags_s1.img_end;
		end
	end

endmodule
`default_nettype wire

@@ design/rpvs_accum.sv @@
// Square and accumulate stage with the result register.
`timescale 1ns / 1ps
`default_nettype none
module rpvs_accum #(
	parameter int unsigned MAX_WIDTH  = rpvs_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = rpvs_pkg::DEF_MAX_HEIGHT,
	localparam int unsigned CNT_W     = $clog2(MAX_WIDTH + 1)
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                ld,
	input  wire logic [CNT_W-1:0]                    diff_s2,
	input  wire rpvs_pkg::row_flags_t                flags_s2,
	input  wire logic                                consume,
	input  wire logic                                out_stall,
	output logic                                     img_end_s3,
	output logic                                     out_valid,
	output logic      [rpvs_pkg::SCORE_OUT_W-1:0]    out_score
);
	import rpvs_pkg::*;

	localparam longint unsigned SCORE_LIMIT =
		longint'(MAX_WIDTH) * longint'(MAX_WIDTH) * longint'(MAX_HEIGHT - 1);
	localparam int unsigned LIMIT_W = $clog2(SCORE_LIMIT + 1);
	localparam int unsigned SCORE_W = (LIMIT_W > SCORE_OUT_W) ? LIMIT_W : SCORE_OUT_W;
	localparam int unsigned SUM_W   = SCORE_W + 1;
	localparam int unsigned SQ_W    = 2 * CNT_W;

	logic [SQ_W-1:0]    sq_s3;
	logic [SCORE_W-1:0] score_q;
	logic [SUM_W-1:0]   sum;
	logic [SCORE_W-1:0] sum_sat;
	logic               out_valid_q;

	// Square of the row difference
	always_ff @(posedge clk) begin
		if (ld) begin
			sq_s3      <= flags_s2.add ? (SQ_W'(diff_s2) * SQ_W'(diff_s2)) : '0;
			img_end_s3 <= flags_s2.img_end;
		end
	end

	// Saturating accumulate
	always_comb begin
		sum = SUM_W'(score_q) + SUM_W'(sq_s3);
		if (sum > SUM_W'(SCORE_LIMIT)) begin
			sum_sat = SCORE_W'(SCORE_LIMIT);
		end else begin
			sum_sat = sum[SCORE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
		end else if (consume) begin
			score_q <= img_end_s3 ? '0 : sum_sat;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (consume && img_end_s3) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && img_end_s3) begin
			out_score <= sum_sat[SCORE_OUT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

@@ design/row_profile_variation_score.sv @@
// Top level of the row profile variation score block.
//
// Input channel: one request per 32-bit pixel word (bit 31 leftmost, 1 = black),
// with last_in_row and last_in_image flags, under in_valid / in_stall.
// Output channel: one request carrying score per image, under out_valid /
// out_stall. Words that do not end an image produce no output.
// Config: cfg_wr_en with image_width writes the width register; the new mask
// applies from the next word accepted and the running state is kept.
// Throughput: one word per cycle while in_stall is low. Four parallel lanes
// count the word's pixels and a merge stage folds them into the row count in the
// same cycle it updates the row state; that recurrence sets the rate.
// Path: the image's last word passes the lane count, merge, square and result
// registers before the score is visible; stalls can hold it at any of them.
// Reset: pipeline empties, width returns to 4096, row counts and running score clear.
// Stall: the result register holds a waiting score while out_stall is high; words keep
// flowing until an image-ending word reaches the accumulator while the
// previous score is still waiting; in_stall rises when the stages behind fill.
`timescale 1ns / 1ps
`default_nettype none
module row_profile_variation_score #(
	parameter int unsigned MAX_WIDTH  = rpvs_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = rpvs_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [rpvs_pkg::CFG_W-1:0]        image_width,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [rpvs_pkg::WORD_W-1:0]       pixel_word,
	input  wire logic                              last_in_row,
	input  wire logic                              last_in_image,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [rpvs_pkg::SCORE_OUT_W-1:0]  score
);
	import rpvs_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_WIDTH + 1);

	logic [WORD_W-1:0] mask_q;
	logic [WORD_W-1:0] word_m;
	word_flags_t       flags_in;
	word_flags_t       flags_s1;
	row_flags_t        flags_s2;
	logic [NUM_LANES-1:0][LANE_CNT_W-1:0] lane_cnt_s1;
	logic [CNT_W-1:0]  diff_s2;
	logic              img_end_s3;
	logic              v1_q, v2_q, v3_q;
	logic              adv1, adv2, adv3, consume;
	logic              out_free;

	// Width register, kept as the row-end mask
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= row_end_mask(IMAGE_WIDTH_RST);
		end else if (cfg_wr_en) begin
			mask_q <= row_end_mask(image_width);
		end
	end

	// Stage advance chain
	always_comb begin
		out_free = !out_valid || !out_stall;
		consume  = v3_q && (!img_end_s3 || out_free);
		adv3     = !v3_q || consume;
		adv2     = !v2_q || adv3;
		adv1     = !v1_q || adv2;
	end

	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (adv1) v1_q <= in_valid;
			if (adv2) v2_q <= v1_q;
			if (adv3) v3_q <= v2_q;
		end
	end

	// Row-end masking; an image end also ends the row
	always_comb begin
		flags_in.img_end = last_in_image;
		flags_in.row_end = last_in_row || last_in_image;
		word_m = flags_in.row_end ? (pixel_word & mask_q) : pixel_word;
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			flags_s1 <= flags_in;
		end
	end

	// Popcount lanes
	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		rpvs_lane u_lane (
			.clk    (clk),
			.en     (adv1),
			.bits   (word_m[g*LANE_W +: LANE_W]),
			.cnt_s1 (lane_cnt_s1[g])
		);
	end

	rpvs_merge #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (adv2 && v1_q),
		.lane_cnt_s1 (lane_cnt_s1),
		.flags_s1    (flags_s1),
		.diff_s2     (diff_s2),
		.flags_s2    (flags_s2)
	);

	rpvs_accum #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld         (adv3 && v2_q),
		.diff_s2    (diff_s2),
		.flags_s2   (flags_s2),
		.consume    (consume),
		.out_stall  (out_stall),
		.img_end_s3 (img_end_s3),
		.out_valid  (out_valid),
		.out_score  (score)
	);

endmodule
`default_nettype wire
